[src/dbms_pkg.sv]
// ----------------------------------------------------------------------------
// dbms_pkg
// Shared types, constants and register indexes of the depth box mask segmenter.
// ----------------------------------------------------------------------------
package dbms_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int COUNT_BITS_DEF = 24;
  localparam int DEPTH_W        = 20;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_CENTRE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_HALF    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MARGIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_ORIENT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PIXELS  = 3'd6;

  localparam logic [15:0] MARGIN_RESET = 16'd40;
  localparam logic [23:0] MIN_PIX_RESET = 24'd50;

  typedef struct packed {
    logic [11:0] pixel_column;
    logic [11:0] pixel_row;
    logic [19:0] depth_value;
    logic        final_pixel;
  } in_item_t;

  typedef struct packed {
    logic        inside_res;
    logic        run_done;
    logic        accepted;
    logic [23:0] hit_count;
    logic [11:0] hit_left;
    logic [11:0] hit_top;
    logic [12:0] hit_width;
    logic [12:0] hit_height;
  } out_item_t;

  typedef struct packed {
    logic [63:0] inverse_focal;
    logic [31:0] principal_point;
    logic [62:0] box_centre;
    logic [62:0] box_half_size;
    logic [15:0] box_margin;
    logic [63:0] box_orientation;
    logic [23:0] min_hits;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_OFFS,
    ST_ROT0,
    ST_ROT1,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic cap_in;
    logic mul0;
    logic mul1;
    logic offs;
    logic rot0;
    logic rot1;
    logic upd;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

[src/dbms_ctrl.sv]
// ----------------------------------------------------------------------------
// dbms_ctrl
// Sequencer that steps one pixel through the datapath stages.
// ----------------------------------------------------------------------------
module dbms_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  dbms_pkg::stat_t stat,
  output dbms_pkg::cmd_t  cmd
);
  import dbms_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_MUL0;
      end
      ST_MUL0: state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_OFFS;
      ST_OFFS: state_nxt = ST_ROT0;
      ST_ROT0: state_nxt = ST_ROT1;
      ST_ROT1: state_nxt = ST_DONE;
      ST_DONE: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.cap_in = in_valid;
      end
      ST_MUL0: cmd.mul0 = 1'b1;
      ST_MUL1: cmd.mul1 = 1'b1;
      ST_OFFS: cmd.offs = 1'b1;
      ST_ROT0: cmd.rot0 = 1'b1;
      ST_ROT1: cmd.rot1 = 1'b1;
      ST_DONE: cmd.upd  = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

[src/dbms_dp.sv]
// ----------------------------------------------------------------------------
// dbms_dp
// Back-projection, box rotation, inside test, run statistics, result register.
// ----------------------------------------------------------------------------
module dbms_dp #(
  parameter int COORD_BITS = dbms_pkg::COORD_BITS_DEF,
  parameter int COUNT_BITS = dbms_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dbms_pkg::cmd_t      cmd,
  output dbms_pkg::stat_t     stat,
  input  dbms_pkg::cfg_t      cfg,
  input  dbms_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dbms_pkg::out_item_t out_data
);
  import dbms_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int XW  = (CB + 4 > 16) ? CB + 4 : 16;  // pixel offset magnitude
  localparam int DW  = XW + 1;                       // signed pixel offset
  localparam int MZW = XW + DEPTH_W;
  localparam int PHW = XW + DEPTH_W + 16;
  localparam int RW  = PHW - 18;
  localparam int PSW = RW + 1;
  localparam int EW  = RW + 2;
  localparam int CFW = 35;
  localparam int MW  = 62;
  localparam int LW  = 64;
  localparam int KW  = (COUNT_BITS > 24) ? COUNT_BITS : 24;
  localparam logic signed [26:0] D_LIM = 27'sd67108863;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // Captured pixel
  logic [CB-1:0]      col_r, row_r;
  logic [DEPTH_W-1:0] z_r;
  logic               fin_r;

  // Stage products
  logic [MZW-1:0]     mzx_r, mzy_r;
  logic               sgu_r, sgv_r;
  logic signed [31:0] pww_r, pxx_r, pyy_r, pzz_r, pxy_r, pwq_r, pxq_r, pwy_r, pyq_r, pwx_r;
  logic [PHW-1:0]     phx_r, plx_r, phy_r, ply_r;
  logic signed [CFW-1:0] a00_r, a01_r, a02_r, a10_r, a11_r, a12_r, a20_r, a21_r, a22_r;
  logic signed [26:0] dx_r, dy_r, dz_r;
  logic signed [MW-1:0] m00_r, m10_r, m20_r, m01_r, m11_r, m21_r, m02_r, m12_r, m22_r;
  logic               hit_r;

  // Run statistics
  logic [COUNT_BITS-1:0] cnt_r;
  logic [CB-1:0]         lc_r, lr_r, gc_r, gr_r;

  out_item_t out_r;
  logic      out_valid_r;

  // ---- MUL0: pixel offsets and depth scaling, quaternion products
  logic signed [DW-1:0] du, dv;
  logic [XW-1:0]        magu, magv;
  logic signed [15:0]   qw, qx, qy, qz;

  always_comb begin
    du = $signed({1'b0, XW'({col_r, 4'b0})}) - $signed({1'b0, XW'(cfg.principal_point[15:0])});
    dv = $signed({1'b0, XW'({row_r, 4'b0})}) - $signed({1'b0, XW'(cfg.principal_point[31:16])});
    magu = du[DW-1] ? XW'(-du) : XW'(du);
    magv = dv[DW-1] ? XW'(-dv) : XW'(dv);
    qw = $signed(cfg.box_orientation[15:0]);
    qx = $signed(cfg.box_orientation[31:16]);
    qy = $signed(cfg.box_orientation[47:32]);
    qz = $signed(cfg.box_orientation[63:48]);
  end

  // ---- OFFS: finish back-projection, offset from centre, saturate
  logic [RW-1:0]         rx, ry;
  logic signed [PSW-1:0] px, py;
  logic signed [EW-1:0]  ex, ey;
  logic signed [22:0]    ez;
  logic signed [26:0]    dx_nxt, dy_nxt, dz_nxt;

  function automatic logic signed [26:0] sat_e(input logic signed [EW-1:0] v);
    if (v > EW'(D_LIM)) return D_LIM;
    else if (v < -EW'(D_LIM)) return -D_LIM;
    else return 27'(v);
  endfunction

  always_comb begin
    rx = RW'((phx_r + (plx_r >> 16)) >> 18);
    ry = RW'((phy_r + (ply_r >> 16)) >> 18);
    px = sgu_r ? -$signed({1'b0, rx}) : $signed({1'b0, rx});
    py = sgv_r ? -$signed({1'b0, ry}) : $signed({1'b0, ry});
    ex = EW'(px) - EW'($signed(cfg.box_centre[20:0]));
    ey = EW'(py) - EW'($signed(cfg.box_centre[41:21]));
    ez = $signed({3'b0, z_r}) - 23'($signed(cfg.box_centre[62:42]));
    dx_nxt = sat_e(ex);
    dy_nxt = sat_e(ey);
    dz_nxt = 27'(ez);
  end

  // ---- ROT1: local coordinates and box test
  logic signed [LW-1:0] lx, ly, lz;
  logic [LW-1:0]        ax, ay, az, hx, hy, hz;
  logic                 hit_nxt;

  always_comb begin
    lx = LW'(m00_r) + LW'(m10_r) + LW'(m20_r);
    ly = LW'(m01_r) + LW'(m11_r) + LW'(m21_r);
    lz = LW'(m02_r) + LW'(m12_r) + LW'(m22_r);
    ax = lx[LW-1] ? LW'(-lx) : LW'(lx);
    ay = ly[LW-1] ? LW'(-ly) : LW'(ly);
    az = lz[LW-1] ? LW'(-lz) : LW'(lz);
    hx = LW'(22'(cfg.box_half_size[20:0]) + 22'(cfg.box_margin)) << 28;
    hy = LW'(22'(cfg.box_half_size[41:21]) + 22'(cfg.box_margin)) << 28;
    hz = LW'(22'(cfg.box_half_size[62:42]) + 22'(cfg.box_margin)) << 28;
    hit_nxt = (z_r != '0) && (ax <= hx) && (ay <= hy) && (az <= hz);
  end

  // ---- UPD: statistics and result
  logic [COUNT_BITS-1:0] cnt_nxt;
  logic [CB-1:0]         lc_nxt, lr_nxt, gc_nxt, gr_nxt;
  logic [CB:0]           wid, hgt;
  out_item_t             res;

  always_comb begin
    cnt_nxt = cnt_r;
    lc_nxt  = lc_r;
    lr_nxt  = lr_r;
    gc_nxt  = gc_r;
    gr_nxt  = gr_r;
    if (hit_r) begin
      if (cnt_r != CNT_MAX) cnt_nxt = cnt_r + 1'b1;
      if (col_r < lc_r) lc_nxt = col_r;
      if (row_r < lr_r) lr_nxt = row_r;
      if (col_r > gc_r) gc_nxt = col_r;
      if (row_r > gr_r) gr_nxt = row_r;
    end
    wid = {1'b0, gc_nxt} - {1'b0, lc_nxt} + 1'b1;
    hgt = {1'b0, gr_nxt} - {1'b0, lr_nxt} + 1'b1;
    res = '0;
    res.inside_res = hit_r;
    if (fin_r) begin
      res.run_done  = 1'b1;
      res.hit_count = 24'(cnt_nxt);
      if (cnt_nxt != '0) begin
        res.accepted   = KW'(cnt_nxt) >= KW'(cfg.min_hits);
        res.hit_left   = 12'(lc_nxt);
        res.hit_top    = 12'(lr_nxt);
        res.hit_width  = 13'(wid);
        res.hit_height = 13'(hgt);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      col_r <= CB'(in_data.pixel_column);
      row_r <= CB'(in_data.pixel_row);
      z_r   <= in_data.depth_value;
      fin_r <= in_data.final_pixel;
    end
    if (cmd.mul0) begin
      mzx_r <= magu * z_r;
      mzy_r <= magv * z_r;
      sgu_r <= du[DW-1];
      sgv_r <= dv[DW-1];
      pww_r <= qw * qw;
      pxx_r <= qx * qx;
      pyy_r <= qy * qy;
      pzz_r <= qz * qz;
      pxy_r <= qx * qy;
      pwq_r <= qw * qz;
      pxq_r <= qx * qz;
      pwy_r <= qw * qy;
      pyq_r <= qy * qz;
      pwx_r <= qw * qx;
    end
    if (cmd.mul1) begin
      phx_r <= mzx_r * cfg.inverse_focal[31:16];
      plx_r <= mzx_r * cfg.inverse_focal[15:0];
      phy_r <= mzy_r * cfg.inverse_focal[63:48];
      ply_r <= mzy_r * cfg.inverse_focal[47:32];
      a00_r <= CFW'(pww_r) + CFW'(pxx_r) - CFW'(pyy_r) - CFW'(pzz_r);
      a11_r <= CFW'(pww_r) - CFW'(pxx_r) + CFW'(pyy_r) - CFW'(pzz_r);
      a22_r <= CFW'(pww_r) - CFW'(pxx_r) - CFW'(pyy_r) + CFW'(pzz_r);
      a01_r <= (CFW'(pxy_r) - CFW'(pwq_r)) <<< 1;
      a10_r <= (CFW'(pxy_r) + CFW'(pwq_r)) <<< 1;
      a02_r <= (CFW'(pxq_r) + CFW'(pwy_r)) <<< 1;
      a20_r <= (CFW'(pxq_r) - CFW'(pwy_r)) <<< 1;
      a12_r <= (CFW'(pyq_r) - CFW'(pwx_r)) <<< 1;
      a21_r <= (CFW'(pyq_r) + CFW'(pwx_r)) <<< 1;
    end
    if (cmd.offs) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      dz_r <= dz_nxt;
    end
    if (cmd.rot0) begin
      m00_r <= a00_r * dx_r;
      m10_r <= a10_r * dy_r;
      m20_r <= a20_r * dz_r;
      m01_r <= a01_r * dx_r;
      m11_r <= a11_r * dy_r;
      m21_r <= a21_r * dz_r;
      m02_r <= a02_r * dx_r;
      m12_r <= a12_r * dy_r;
      m22_r <= a22_r * dz_r;
    end
    if (cmd.rot1) begin
      hit_r <= hit_nxt;
    end
    if (cmd.upd) begin
      out_r <= res;
    end
  end

  // Run state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      lc_r        <= '1;
      lr_r        <= '1;
      gc_r        <= '0;
      gr_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.upd) begin
        if (fin_r) begin
          cnt_r <= '0;
          lc_r  <= '1;
          lr_r  <= '1;
          gc_r  <= '0;
          gr_r  <= '0;
        end else begin
          cnt_r <= cnt_nxt;
          lc_r  <= lc_nxt;
          lr_r  <= lr_nxt;
          gc_r  <= gc_nxt;
          gr_r  <= gr_nxt;
        end
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

endmodule

[src/depth_box_mask_segmenter_top.sv]
// ----------------------------------------------------------------------------
// depth_box_mask_segmenter_top
// Box test of back-projected depth pixels with per-run hit count and box.
// ----------------------------------------------------------------------------
// The sequencer takes a new pixel only while idle, so one pixel is in flight at
//   a time; it walks each pixel through six datapath steps (two multiply steps,
//   offset, two rotation steps, update).
// A result waiting on the output stalls only the update step.
// Reset (synchronous, rst_n low): sequencer idle, output empty, run state
//   cleared, registers at their defaults (margin 40, minimum pixels 50).
// ----------------------------------------------------------------------------
module depth_box_mask_segmenter_top #(
  parameter int COORD_BITS = dbms_pkg::COORD_BITS_DEF,
  parameter int COUNT_BITS = dbms_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  dbms_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output dbms_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dbms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dbms_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dbms_pkg::*;

  cfg_t  cfg_r;
  cmd_t  cmd;
  stat_t stat;

  // Configuration writes are always taken; the user must send them only while no
  // pixel is in flight: the block itself does not enforce this and has no hold-off.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inverse_focal   <= '0;
      cfg_r.principal_point <= '0;
      cfg_r.box_centre      <= '0;
      cfg_r.box_half_size   <= '0;
      cfg_r.box_margin      <= MARGIN_RESET;
      cfg_r.box_orientation <= '0;
      cfg_r.min_hits        <= MIN_PIX_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_INV_FOCAL:  cfg_r.inverse_focal   <= cfg_data;
        REG_PRINCIPAL:  cfg_r.principal_point <= cfg_data[31:0];
        REG_BOX_CENTRE: cfg_r.box_centre      <= cfg_data[62:0];
        REG_BOX_HALF:   cfg_r.box_half_size   <= cfg_data[62:0];
        REG_BOX_MARGIN: cfg_r.box_margin      <= cfg_data[15:0];
        REG_BOX_ORIENT: cfg_r.box_orientation <= cfg_data;
        REG_MIN_PIXELS: cfg_r.min_hits        <= cfg_data[23:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Sequencer: idles until a pixel, then one step a cycle; the update can stall
  dbms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: projection, rotation, box test, run statistics, output register
  dbms_dp #(
    .COORD_BITS (COORD_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cfg       (cfg_r),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Acceptance needs a finished run with at least one hit
  a_accept_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.accepted |-> out_data.run_done && out_data.hit_count != '0)
    else $error("accepted without a closed run with hits");

  // Summary fields stay zero on results of non-final pixels
  a_nonfinal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.run_done |-> out_data.hit_count == '0 && out_data.hit_width == '0)
    else $error("summary fields set on a non-final pixel");

  // Busy after a pixel transaction until its steps are done
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new pixel taken while one is in flight");

  // A final pixel that hits always reports a nonzero count
  a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.inside_res && out_data.run_done |-> out_data.hit_count != '0)
    else $error("final hit not counted");

endmodule

[sim/depth_box_mask_segmenter_top_tb.sv]
// ----------------------------------------------------------------------------
// depth_box_mask_segmenter_top_tb
// Self-checking bench: streams depth pixel runs through the segmenter under
// several register settings and handshake idling patterns, predicts each
// result in-bench and compares it field by field with the block's output.
// ----------------------------------------------------------------------------
module depth_box_mask_segmenter_top_tb;
  import dbms_pkg::*;

  localparam int        STALL_LIMIT = 20000;
  localparam int        TAIL_CYCLES = 40;
  localparam int        N_RANDOM    = 1130;
  localparam int        MAX_REPORTS = 10;
  localparam logic [63:0] D_LIMIT   = 64'd67108863;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  depth_box_mask_segmenter_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor copy of the register file and the run state.
  logic [63:0] m_inv_focal;
  logic [31:0] m_principal;
  logic [62:0] m_centre;
  logic [62:0] m_half;
  logic [15:0] m_margin;
  logic [63:0] m_orient;
  logic [23:0] m_min_pix;
  logic [23:0] run_hits;
  logic [11:0] run_left, run_top, run_right, run_bottom;

  in_item_t  pixel_queue[$];
  out_item_t segment_expected[$];

  int  idle_pct_in, idle_pct_out;
  int  mismatch_count;
  int  results_seen, runs_seen, runs_accepted, hits_seen;
  int  stall_cycles;
  bit  timed_out;
  bit  in_taken;

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // Back-projection: magnitude times depth times Q2.30 inverse focal, / 2^34.
  function automatic longint project_axis(longint offs, logic [19:0] z, logic [31:0] inv);
    logic [63:0] mag, r;
    mag = (offs < 0) ? 64'(-offs) : 64'(offs);
    mag = mag * 64'(z);
    r = (mag * 64'(inv[31:16]) + ((mag * 64'(inv[15:0])) >> 16)) >> 18;
    return (offs < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clamp_offset(longint v);
    if (v > longint'(D_LIMIT)) return longint'(D_LIMIT);
    if (v < -longint'(D_LIMIT)) return -longint'(D_LIMIT);
    return v;
  endfunction

  function automatic bit axis_fits(longint l, logic [63:0] lim);
    logic [63:0] a;
    a = (l < 0) ? 64'(-l) : 64'(l);
    return a <= (lim << 28);
  endfunction

  function automatic bit pixel_in_box(logic [11:0] col, logic [11:0] row, logic [19:0] z);
    longint du, dv, px, py, dx, dy, dz, w, x, y, q;
    longint a00, a11, a22, a01, a10, a02, a20, a12, a21, lx, ly, lz;
    logic [63:0] hx, hy, hz;
    du = longint'({col, 4'b0}) - longint'(m_principal[15:0]);
    dv = longint'({row, 4'b0}) - longint'(m_principal[31:16]);
    px = project_axis(du, z, m_inv_focal[31:0]);
    py = project_axis(dv, z, m_inv_focal[63:32]);
    dx = clamp_offset(px - longint'($signed(m_centre[20:0])));
    dy = clamp_offset(py - longint'($signed(m_centre[41:21])));
    dz = clamp_offset(longint'(z) - longint'($signed(m_centre[62:42])));
    w = longint'($signed(m_orient[15:0]));
    x = longint'($signed(m_orient[31:16]));
    y = longint'($signed(m_orient[47:32]));
    q = longint'($signed(m_orient[63:48]));
    a00 = w*w + x*x - y*y - q*q;
    a11 = w*w - x*x + y*y - q*q;
    a22 = w*w - x*x - y*y + q*q;
    a01 = 2*(x*y - w*q); a10 = 2*(x*y + w*q);
    a02 = 2*(x*q + w*y); a20 = 2*(x*q - w*y);
    a12 = 2*(y*q - w*x); a21 = 2*(y*q + w*x);
    lx = a00*dx + a10*dy + a20*dz;
    ly = a01*dx + a11*dy + a21*dz;
    lz = a02*dx + a12*dy + a22*dz;
    hx = 64'(m_half[20:0]) + 64'(m_margin);
    hy = 64'(m_half[41:21]) + 64'(m_margin);
    hz = 64'(m_half[62:42]) + 64'(m_margin);
    return axis_fits(lx, hx) && axis_fits(ly, hy) && axis_fits(lz, hz);
  endfunction

  function automatic void clear_segment();
    run_hits = '0;
    run_left = '1;
    run_top = '1;
    run_right = '0;
    run_bottom = '0;
  endfunction

  // Advance the run state by one pixel and return its expected result.
  function automatic out_item_t segment_pixel(in_item_t p);
    out_item_t r;
    bit hit;
    hit = (p.depth_value != 0) && pixel_in_box(p.pixel_column, p.pixel_row, p.depth_value);
    if (hit) begin
      if (run_hits != '1) run_hits++;
      if (p.pixel_column < run_left) run_left = p.pixel_column;
      if (p.pixel_row < run_top) run_top = p.pixel_row;
      if (p.pixel_column > run_right) run_right = p.pixel_column;
      if (p.pixel_row > run_bottom) run_bottom = p.pixel_row;
    end
    r = '0;
    r.inside_res = hit;
    if (p.final_pixel) begin
      r.run_done = 1'b1;
      r.hit_count = run_hits;
      if (run_hits != 0) begin
        r.accepted = run_hits >= m_min_pix;
        r.hit_left = run_left;
        r.hit_top = run_top;
        r.hit_width = 13'(run_right) - 13'(run_left) + 13'd1;
        r.hit_height = 13'(run_bottom) - 13'(run_top) + 13'd1;
      end
      clear_segment();
    end
    return r;
  endfunction

  // Driver: present queued pixels, idling at the phase's rate.
  // Hold the current pixel until the monitor saw it taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pixel_queue.size() != 0 && $urandom_range(99) >= idle_pct_in) begin
        in_valid <= 1'b1;
        in_data  <= pixel_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= rst_n && ($urandom_range(99) >= idle_pct_out);
  end

  // Monitor: predict on input transactions, check on output transactions.
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready)
        segment_expected = {segment_expected, segment_pixel(in_data)};
      if (out_valid && out_ready) begin
        results_seen++;
        if (segment_expected.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("ERROR unexpected result %p", out_data);
        end else begin
          out_item_t e;
          e = segment_expected.pop_front();
          if (e.run_done) begin
            runs_seen++;
            if (e.accepted) runs_accepted++;
          end
          if (e.inside_res) hits_seen++;
          if (out_data !== e) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("ERROR result mismatch: expected %p actual %p", e, out_data);
          end
        end
      end
      // Watchdog: count cycles with no transaction on any channel.
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (stall_cycles >= STALL_LIMIT) begin
      $display("ERROR watchdog expired");
      $display("FAIL depth_box_mask_segmenter_top");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_INV_FOCAL:  m_inv_focal = val;
      REG_PRINCIPAL:  m_principal = val[31:0];
      REG_BOX_CENTRE: m_centre = val[62:0];
      REG_BOX_HALF:   m_half = val[62:0];
      REG_BOX_MARGIN: m_margin = val[15:0];
      REG_BOX_ORIENT: m_orient = val;
      REG_MIN_PIXELS: m_min_pix = val[23:0];
      default: ;
    endcase
  endtask

  // Wait for every queued pixel and its result, then let the pipe drain.
  task automatic drain();
    while (pixel_queue.size() != 0 || in_valid || segment_expected.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // A camera-like setting: f about 600 px, principal point near the centre.
  task automatic load_camera(logic [15:0] margin, logic [23:0] min_pix, bit rotated);
    logic [20:0] cz;
    cz = 21'($urandom_range(4000, 12000));
    write_reg(REG_INV_FOCAL, {32'd1789570, 32'd1789570});
    write_reg(REG_PRINCIPAL, {16'd64 << 4, 16'd64 << 4});
    write_reg(REG_BOX_CENTRE, {cz, 21'($urandom_range(400)), 21'h1FFF00});
    write_reg(REG_BOX_HALF, {21'd800, 21'($urandom_range(200, 1500)), 21'($urandom_range(200, 1500))});
    write_reg(REG_BOX_MARGIN, 64'(margin));
    write_reg(REG_BOX_ORIENT, rotated ? {16'sd0, 16'sd0, 16'sd6270, 16'sd15137}
                                      : {48'd0, 16'sd16384});
    write_reg(REG_MIN_PIXELS, 64'(min_pix));
  endtask

  // One object window: a small scan with depths near the box, closed by a final pixel.
  task automatic queue_window(int npix);
    in_item_t p;
    for (int i = 0; i < npix; i++) begin
      p.pixel_column = 12'($urandom_range(40, 90));
      p.pixel_row    = 12'($urandom_range(40, 90));
      p.depth_value  = ($urandom_range(9) == 0) ? 20'd0
                       : 20'(m_centre[62:42]) + 20'($urandom_range(1600)) - 20'd800;
      p.final_pixel  = (i == npix - 1);
      pixel_queue = {pixel_queue, p};
    end
  endtask

  task automatic queue_noise(int n);
    in_item_t p;
    for (int i = 0; i < n; i++) begin
      p = in_item_t'($bits(in_item_t)'({$urandom, $urandom}));
      p.final_pixel = ($urandom_range(7) == 0);
      pixel_queue = {pixel_queue, p};
    end
  endtask

  initial begin
    int sent;
    in_item_t p;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_taken = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_pct_in = 0;
    idle_pct_out = 0;
    mismatch_count = 0;
    results_seen = 0;
    runs_seen = 0;
    runs_accepted = 0;
    hits_seen = 0;
    stall_cycles = 0;
    m_inv_focal = '0;
    m_principal = '0;
    m_centre = '0;
    m_half = '0;
    m_margin = MARGIN_RESET;
    m_orient = '0;
    m_min_pix = MIN_PIX_RESET;
    clear_segment();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset registers, field extremes, zero depth, empty run.
    p = '0; pixel_queue = {pixel_queue, p};
    p = '1; pixel_queue = {pixel_queue, p};
    p = '0; p.final_pixel = 1'b1; pixel_queue = {pixel_queue, p};
    p = '1; p.final_pixel = 1'b0; pixel_queue = {pixel_queue, p};
    p = '0; p.depth_value = 20'd1; p.final_pixel = 1'b1; pixel_queue = {pixel_queue, p};
    drain();

    // Directed: everything inside a huge box, min pixels at extremes.
    write_reg(REG_BOX_HALF, '1);
    write_reg(REG_BOX_MARGIN, 64'hFFFF);
    write_reg(REG_BOX_ORIENT, {48'd0, 16'sd16384});
    write_reg(REG_MIN_PIXELS, 64'd0);
    p = '0; p.pixel_column = 12'd4095; p.pixel_row = 12'd0; p.depth_value = 20'd100;
    pixel_queue = {pixel_queue, p};
    p.pixel_column = 12'd0; p.pixel_row = 12'd4095; pixel_queue = {pixel_queue, p};
    p.depth_value = 20'd0; p.final_pixel = 1'b1; pixel_queue = {pixel_queue, p};
    p = '0; p.depth_value = 20'hFFFFF; p.final_pixel = 1'b1; pixel_queue = {pixel_queue, p};
    drain();
    write_reg(REG_MIN_PIXELS, 64'hFFFFFF);
    write_reg(REG_INV_FOCAL, '1);
    write_reg(REG_PRINCIPAL, '1);
    write_reg(REG_BOX_CENTRE, {21'h100000, 21'h0FFFFF, 21'h100000});
    write_reg(REG_BOX_ORIENT, '1);
    p = '1; p.final_pixel = 1'b0; pixel_queue = {pixel_queue, p};
    p = '0; p.pixel_column = 12'd2048; p.depth_value = 20'h80000; pixel_queue = {pixel_queue, p};
    p = '1; pixel_queue = {pixel_queue, p};
    drain();

    // Random phases: each with its own setting and idling pattern.
    sent = 0;
    for (int ph = 0; sent < N_RANDOM; ph++) begin
      case (ph % 4)
        0: begin idle_pct_in = 0;  idle_pct_out = 0;  end
        1: begin idle_pct_in = 45; idle_pct_out = 0;  end
        2: begin idle_pct_in = 0;  idle_pct_out = 45; end
        default: begin idle_pct_in = 8; idle_pct_out = 8; end
      endcase
      load_camera(16'($urandom_range(ph % 3 == 0 ? 0 : 400)),
                  (ph % 5 == 0) ? 24'd0 : 24'($urandom_range(1, 30)), (ph % 2) != 0);
      for (int w = 0; w < 8; w++) begin
        int n;
        n = $urandom_range(1, 30);
        queue_window(n);
        sent += n;
      end
      queue_noise(10);
      sent += 10;
      drain();
    end

    $display("Checked %0d results over %0d runs (%0d accepted, %0d inside pixels).",
             results_seen, runs_seen, runs_accepted, hits_seen);
    if (mismatch_count == 0) begin
      $display("PASS depth_box_mask_segmenter_top");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("FAIL depth_box_mask_segmenter_top");
    end
    $finish;
  end

endmodule
